>>> rtl/core/fbfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and codes for the fixed block free-list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

    // Pool size; port widths follow from it
    localparam int unsigned NUM_BLOCKS = 8;

    // Request codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Field widths of the transaction ports
    localparam int unsigned IDX_W  = $clog2(NUM_BLOCKS);
    localparam int unsigned FREE_W = $clog2(NUM_BLOCKS + 1);

    // Link memory port controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ram_ctl;

endpackage

>>> rtl/core/fbfl_link_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_link_ram
// Link memory: one next-link per block, one write and one registered read
// port.
// ----------------------------------------------------------------------------
module fbfl_link_ram #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = 3,
    parameter int unsigned DW    = 4
) (
    input  logic              i_clk,
    input  fbfl_pkg::t_ram_ctl i_ctl,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DW-1:0]     i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DW-1:0]     o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/fixed_block_free_list_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Free-list pool of NUM_BLOCKS blocks: head pointer and free count in
// registers, one next-link per block in a synchronous memory.
// ----------------------------------------------------------------------------
//  channel   | handshake                   | payload
//  ----------+-----------------------------+-----------------------------------
//  request   | start / busy (taken: start  | i_opcode, i_has_block,
//            | high while busy low)        | i_block_index
//  result    | o_valid, one cycle, no stall| o_granted, o_granted_index,
//            |                             | o_free_blocks
//
//  A new request is taken only once the last one is done. The link of the
//  head is read from the link memory at acceptance (registered read port),
//  and the head, count and link write-back are done in S_EXEC.
//  The result is registered in S_EXEC; busy is already low when it shows.
//  After reset, busy stays high while the link memory is threaded in S_INIT
//  (entry i links to i-1, entry 0 to none).
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_opcode,
    input  logic                         i_has_block,
    input  logic [fbfl_pkg::IDX_W-1:0]   i_block_index,
    output logic                         o_valid,
    output logic                         o_granted,
    output logic [fbfl_pkg::IDX_W-1:0]   o_granted_index,
    output logic [fbfl_pkg::FREE_W-1:0]  o_free_blocks
);

    localparam int unsigned NUM_BLOCKS = fbfl_pkg::NUM_BLOCKS;
    localparam int unsigned AW = $clog2(NUM_BLOCKS);
    localparam int unsigned LW = $clog2(NUM_BLOCKS + 1);
    localparam logic [LW-1:0] NONE_LINK = LW'(NUM_BLOCKS);
    localparam logic [AW-1:0] LAST_IDX  = AW'(NUM_BLOCKS - 1);

    typedef enum logic [2:0] {
        S_INIT = 3'b001,
        S_IDLE = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_init_cnt, n_init_cnt;
    logic [LW-1:0]   r_head, n_head;
    logic [LW-1:0]   r_free, n_free;
    logic            r_op;
    logic            r_has;
    logic [fbfl_pkg::IDX_W-1:0] r_idx;

    fbfl_pkg::t_ram_ctl ram_ctl;
    logic [AW-1:0]   ram_waddr;
    logic [LW-1:0]   ram_wdata;
    logic [LW-1:0]   ram_rdata;

    logic            accept;
    logic            head_ok;
    logic            idx_ok;
    logic            do_pop;
    logic            do_push;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && (r_state == S_IDLE);
    assign head_ok = (r_head < NONE_LINK);
    assign idx_ok  = (32'(r_idx) < 32'(NUM_BLOCKS));
    assign do_pop  = (r_state == S_EXEC) && (r_op == fbfl_pkg::OP_ALLOC) && head_ok;
    assign do_push = (r_state == S_EXEC) && (r_op == fbfl_pkg::OP_FREE) && r_has && idx_ok;

    // Link memory: threading sweep after reset, push writes old head at the
    // freed index; the head's link is read at acceptance.
    always_comb begin
        ram_ctl.rd_en = accept;
        ram_ctl.wr_en = (r_state == S_INIT) || do_push;
        if (r_state == S_INIT) begin
            ram_waddr = r_init_cnt;
            ram_wdata = (r_init_cnt == '0) ? NONE_LINK : LW'(r_init_cnt) - LW'(1);
        end else begin
            ram_waddr = AW'(r_idx);
            ram_wdata = r_head;
        end
    end

    fbfl_link_ram #(
        .DEPTH (NUM_BLOCKS),
        .AW    (AW),
        .DW    (LW)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_ctl   (ram_ctl),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_head[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_init_cnt = r_init_cnt;
        n_head     = r_head;
        n_free     = r_free;
        case (r_state)
            S_INIT: begin
                n_init_cnt = r_init_cnt + AW'(1);
                if (r_init_cnt == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                if (do_pop) begin
                    n_head = ram_rdata;
                    if (r_free != '0) begin
                        n_free = r_free - LW'(1);
                    end
                end else if (do_push) begin
                    n_head = LW'(r_idx);
                    if (r_free < NONE_LINK) begin
                        n_free = r_free + LW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_init_cnt <= '0;
            r_head     <= LW'(NUM_BLOCKS - 1);
            r_free     <= NONE_LINK;
            o_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_init_cnt <= n_init_cnt;
            r_head     <= n_head;
            r_free     <= n_free;
            o_valid    <= (r_state == S_EXEC);
        end
    end

    // Request capture and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_opcode;
            r_has <= i_has_block;
            r_idx <= i_block_index;
        end
        if (r_state == S_EXEC) begin
            o_granted       <= do_pop;
            o_granted_index <= do_pop ? fbfl_pkg::IDX_W'(r_head) : '0;
            o_free_blocks   <= fbfl_pkg::FREE_W'(n_free);
        end
    end

endmodule

>>> rtl/core/fbfl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfl_checker
// Port-level checks for the free-list allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fbfl_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         i_opcode,
    input logic                         o_valid,
    input logic                         o_granted,
    input logic [fbfl_pkg::IDX_W-1:0]   o_granted_index
);

    // Every accepted transaction is followed by a result
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("missing result after accepted transaction");

    // No result without an accepted transaction before it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without transaction");

    // A free never grants a block
    a_free_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ($past(i_opcode, 2) == fbfl_pkg::OP_FREE)) |-> !o_granted)
        else $error("free transaction reported a grant");

    // Index is zero whenever nothing was granted
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_granted) |-> (o_granted_index == '0))
        else $error("nonzero index without grant");

endmodule

bind fixed_block_free_list_allocator fbfl_checker u_fbfl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_opcode        (i_opcode),
    .o_valid         (o_valid),
    .o_granted       (o_granted),
    .o_granted_index (o_granted_index)
);
